/* design/i2cms_pkg.sv */
// shared types and constants of the i2c master transfer sequencer
// no dependencies; imported by i2cms_byte_ram and the top level
package i2cms_pkg;

    localparam int BYTE_W   = 8;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 4;
    localparam int ACTION_W = 3;
    localparam int ADDR7_W  = 7;
    localparam int LEVEL_W  = 7;

    // request fields inside s_tdata, lowest bit up
    localparam int IN_DATA_W   = 24;
    localparam int IN_BLOCK_LO = 0;
    localparam int IN_BYTE_LO  = 1;
    localparam int IN_LEN_LO   = 9;
    localparam int IN_STAT_LO  = 17;

    // result width inside m_tdata
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USED_W = 34;

    // request opcodes
    localparam logic [OP_W-1:0] OP_LOAD_TX    = 3'd0;
    localparam logic [OP_W-1:0] OP_START_WR   = 3'd1;
    localparam logic [OP_W-1:0] OP_START_RD   = 3'd2;
    localparam logic [OP_W-1:0] OP_BUS_EVENT  = 3'd3;
    localparam logic [OP_W-1:0] OP_STOP       = 3'd4;
    localparam logic [OP_W-1:0] OP_POP_RX     = 3'd5;

    // bus status codes
    localparam logic [STATUS_W-1:0] ST_START      = 4'd0;
    localparam logic [STATUS_W-1:0] ST_REP_START  = 4'd1;
    localparam logic [STATUS_W-1:0] ST_SLAW_ACK   = 4'd2;
    localparam logic [STATUS_W-1:0] ST_SLAW_NACK  = 4'd3;
    localparam logic [STATUS_W-1:0] ST_DATA_ACK   = 4'd4;
    localparam logic [STATUS_W-1:0] ST_DATA_NACK  = 4'd5;
    localparam logic [STATUS_W-1:0] ST_SLAR_ACK   = 4'd7;
    localparam logic [STATUS_W-1:0] ST_SLAR_NACK  = 4'd8;
    localparam logic [STATUS_W-1:0] ST_RX_ACK     = 4'd9;
    localparam logic [STATUS_W-1:0] ST_RX_NACK    = 4'd10;

    // bus actions
    localparam logic [ACTION_W-1:0] ACT_NONE      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_START     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SEND_ADDR = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SEND_DATA = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_STOP      = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_RX_ACK    = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_RX_NACK   = 3'd6;

    // read/write bit of the address byte
    localparam logic DIR_READ = 1'b1;

    // result fields held between the decode stage and the output stage
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [BYTE_W-1:0]   bus_byte;
        logic                sel_tx_data;
        logic                sel_rx_data;
        logic                dropped;
        logic                tx_busy;
        logic                rx_busy;
        logic [LEVEL_W-1:0]  rx_level;
        logic [LEVEL_W-1:0]  tx_level;
    } stage_t;

endpackage

/* design/i2c_master_transfer_sequencer_top.sv */
// top level of the i2c master transfer sequencer
// depends on i2cms_pkg and i2cms_byte_ram
//
// Usage: each request on the s_ side carries an opcode in s_tuser (load tx
// byte, start write, start read, bus event, stop, pop rx byte) and its
// arguments in s_tdata. Every request yields exactly one result on the m_
// side: the next bus action in m_tuser, plus bus byte, popped rx byte, the
// drop flag, busy flags and both fifo levels in m_tdata. The slave address
// is written through cfg_wr_en / cfg_wr_data while the block is idle.
// Each accepted request is registered in the middle stage, then in the output
// register that drives m_tvalid. Throughput: one request per cycle unless
// m_tready stalls the output. The transmit and receive bytes live in two
// single-port-read memories; a request reads or writes its memory in the decode
// cycle and the read data is picked up when it moves into the output register,
// so both stages overlap across requests. Reset clears pointers, counters and
// busy flags; memory contents stay undefined until written. When m_tready is low
// the output register holds its result, one more request is taken into the
// middle stage, and s_tready then drops until the output drains.
module i2c_master_transfer_sequencer_top #(
    parameter int TX_DEPTH = 64,
    parameter int RX_DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // slave address register
    input  logic                              cfg_wr_en,
    input  logic [i2cms_pkg::ADDR7_W-1:0]     cfg_wr_data,
    // request channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // block_start[0], load_byte[8:1], rx_length[16:9], bus_status[20:17]
    input  logic [i2cms_pkg::IN_DATA_W-1:0]   s_tdata,
    // opcode[2:0]
    input  logic [i2cms_pkg::OP_W-1:0]        s_tuser,
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // bus_byte[7:0], rx_byte[15:8], rx_byte_valid[16], write_dropped[17],
    // tx_busy[18], rx_busy[19], rx_level[26:20], tx_level[33:27]
    output logic [i2cms_pkg::OUT_DATA_W-1:0]  m_tdata,
    // bus_action[2:0]
    output logic [i2cms_pkg::ACTION_W-1:0]    m_tuser
);
    import i2cms_pkg::*;

    localparam int TX_CNT_W  = $clog2(TX_DEPTH + 1);
    localparam int RX_CNT_W  = $clog2(RX_DEPTH + 1);
    localparam int TX_ADDR_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int RX_ADDR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam logic [TX_CNT_W-1:0] TX_FULL = TX_CNT_W'(TX_DEPTH);
    localparam logic [RX_CNT_W-1:0] RX_FULL = RX_CNT_W'(RX_DEPTH);

    // request fields
    logic                in_block;
    logic [BYTE_W-1:0]   in_byte;
    logic [BYTE_W-1:0]   in_len;
    logic [STATUS_W-1:0] in_status;
    logic                in_accept;

    // control state
    logic [ADDR7_W-1:0]  target_addr_reg;
    logic [TX_CNT_W-1:0] tx_wr_ptr_reg, tx_wr_ptr_next;
    logic [TX_CNT_W-1:0] tx_rd_ptr_reg, tx_rd_ptr_next;
    logic [RX_CNT_W-1:0] rx_wr_ptr_reg, rx_wr_ptr_next;
    logic [RX_CNT_W-1:0] rx_rd_ptr_reg, rx_rd_ptr_next;
    logic [BYTE_W-1:0]   acks_left_reg, acks_left_next;
    logic                read_dir_reg, read_dir_next;
    logic                tx_active_reg, tx_active_next;
    logic                rx_active_reg, rx_active_next;
    logic [TX_CNT_W-1:0] tx_fill_base;
    logic [TX_CNT_W-1:0] tx_diff;
    logic [RX_CNT_W-1:0] rx_diff;

    // memory ports
    logic                 tx_wr_en, tx_rd_en, rx_wr_en, rx_rd_en;
    logic [TX_ADDR_W-1:0] tx_wr_addr, tx_rd_addr;
    logic [RX_ADDR_W-1:0] rx_wr_addr, rx_rd_addr;
    logic [BYTE_W-1:0]    tx_rd_data, rx_rd_data;

    // pipeline
    stage_t              s1;
    stage_t              s2_reg;
    logic                s2_valid_reg;
    logic                s2_move;
    logic                out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [ACTION_W-1:0] out_action_reg;
    logic [BYTE_W-1:0]   s2_bus_byte;
    logic [BYTE_W-1:0]   s2_rx_byte;

    assign in_block  = s_tdata[IN_BLOCK_LO];
    assign in_byte   = s_tdata[IN_BYTE_LO +: BYTE_W];
    assign in_len    = s_tdata[IN_LEN_LO +: BYTE_W];
    assign in_status = s_tdata[IN_STAT_LO +: STATUS_W];

    // handshake: the middle stage takes a request when it is empty or moving on
    assign s2_move   = s2_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !s2_valid_reg || s2_move;
    assign in_accept = s_tvalid && s_tready;

    // fill base of a load, emptied first on block start
    assign tx_fill_base = in_block ? '0 : tx_wr_ptr_reg;

    // decode: state update, memory access and result fields
    always_comb
    begin
        tx_wr_ptr_next = tx_wr_ptr_reg;
        tx_rd_ptr_next = tx_rd_ptr_reg;
        rx_wr_ptr_next = rx_wr_ptr_reg;
        rx_rd_ptr_next = rx_rd_ptr_reg;
        acks_left_next = acks_left_reg;
        read_dir_next  = read_dir_reg;
        tx_active_next = tx_active_reg;
        rx_active_next = rx_active_reg;
        tx_wr_en       = 1'b0;
        tx_rd_en       = 1'b0;
        rx_wr_en       = 1'b0;
        rx_rd_en       = 1'b0;
        tx_wr_addr     = tx_fill_base[TX_ADDR_W-1:0];
        tx_rd_addr     = tx_rd_ptr_reg[TX_ADDR_W-1:0];
        rx_wr_addr     = rx_wr_ptr_reg[RX_ADDR_W-1:0];
        rx_rd_addr     = rx_rd_ptr_reg[RX_ADDR_W-1:0];
        s1             = '0;
        s1.action      = ACT_NONE;
        if (in_accept)
        begin
            unique case (s_tuser)
                OP_LOAD_TX:
                begin
                    if (in_block)
                    begin
                        tx_rd_ptr_next = '0;
                    end
                    if (tx_fill_base < TX_FULL)
                    begin
                        tx_wr_en       = 1'b1;
                        tx_wr_ptr_next = tx_fill_base + 1'b1;
                    end
                    else
                    begin
                        tx_wr_ptr_next = tx_fill_base;
                        s1.dropped     = 1'b1;
                    end
                end
                OP_START_WR:
                begin
                    read_dir_next  = 1'b0;
                    tx_active_next = 1'b1;
                    tx_rd_ptr_next = '0;
                    s1.action      = ACT_START;
                end
                OP_START_RD:
                begin
                    read_dir_next  = DIR_READ;
                    acks_left_next = in_len;
                    rx_wr_ptr_next = '0;
                    rx_rd_ptr_next = '0;
                    rx_active_next = 1'b1;
                    s1.action      = ACT_START;
                end
                OP_BUS_EVENT:
                begin
                    unique case (in_status)
                        ST_START, ST_REP_START:
                        begin
                            s1.action   = ACT_SEND_ADDR;
                            s1.bus_byte = {target_addr_reg, read_dir_reg};
                        end
                        ST_SLAW_ACK, ST_DATA_ACK:
                        begin
                            if (tx_rd_ptr_reg < tx_wr_ptr_reg)
                            begin
                                tx_rd_en       = 1'b1;
                                tx_rd_ptr_next = tx_rd_ptr_reg + 1'b1;
                                s1.action      = ACT_SEND_DATA;
                                s1.sel_tx_data = 1'b1;
                            end
                            else
                            begin
                                s1.action      = ACT_STOP;
                                tx_active_next = 1'b0;
                            end
                        end
                        ST_RX_ACK, ST_SLAR_ACK:
                        begin
                            // store the acked byte when there is room
                            if (in_status == ST_RX_ACK && rx_wr_ptr_reg < RX_FULL)
                            begin
                                rx_wr_en       = 1'b1;
                                rx_wr_ptr_next = rx_wr_ptr_reg + 1'b1;
                            end
                            if (acks_left_reg != '0)
                            begin
                                s1.action      = ACT_RX_ACK;
                                acks_left_next = acks_left_reg - 1'b1;
                            end
                            else
                            begin
                                s1.action      = ACT_RX_NACK;
                                rx_active_next = 1'b0;
                            end
                        end
                        ST_SLAW_NACK, ST_DATA_NACK, ST_SLAR_NACK, ST_RX_NACK:
                        begin
                            s1.action      = ACT_STOP;
                            tx_active_next = 1'b0;
                            rx_active_next = 1'b0;
                        end
                        default:
                        begin
                            s1.action = ACT_NONE;
                        end
                    endcase
                end
                OP_STOP:
                begin
                    s1.action      = ACT_STOP;
                    tx_active_next = 1'b0;
                    rx_active_next = 1'b0;
                end
                OP_POP_RX:
                begin
                    if (rx_rd_ptr_reg < rx_wr_ptr_reg)
                    begin
                        rx_rd_en       = 1'b1;
                        rx_rd_ptr_next = rx_rd_ptr_reg + 1'b1;
                        s1.sel_rx_data = 1'b1;
                    end
                end
                default:
                begin
                    s1.action = ACT_NONE;
                end
            endcase
        end
        s1.tx_busy  = tx_active_next;
        s1.rx_busy  = rx_active_next;
        s1.tx_level = LEVEL_W'(tx_diff);
        s1.rx_level = LEVEL_W'(rx_diff);
    end

    // levels after the request
    assign tx_diff = tx_wr_ptr_next - tx_rd_ptr_next;
    assign rx_diff = rx_wr_ptr_next - rx_rd_ptr_next;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_addr_reg <= '0;
            tx_wr_ptr_reg   <= '0;
            tx_rd_ptr_reg   <= '0;
            rx_wr_ptr_reg   <= '0;
            rx_rd_ptr_reg   <= '0;
            acks_left_reg   <= '0;
            read_dir_reg    <= 1'b0;
            tx_active_reg   <= 1'b0;
            rx_active_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                target_addr_reg <= cfg_wr_data;
            end
            tx_wr_ptr_reg <= tx_wr_ptr_next;
            tx_rd_ptr_reg <= tx_rd_ptr_next;
            rx_wr_ptr_reg <= rx_wr_ptr_next;
            rx_rd_ptr_reg <= rx_rd_ptr_next;
            acks_left_reg <= acks_left_next;
            read_dir_reg  <= read_dir_next;
            tx_active_reg <= tx_active_next;
            rx_active_reg <= rx_active_next;
        end
    end

    // byte stores
    i2cms_byte_ram #(
        .DEPTH  (TX_DEPTH),
        .ADDR_W (TX_ADDR_W)
    ) u_tx_ram (
        .clk     (clk),
        .wr_en   (tx_wr_en),
        .wr_addr (tx_wr_addr),
        .wr_data (in_byte),
        .rd_en   (tx_rd_en),
        .rd_addr (tx_rd_addr),
        .rd_data (tx_rd_data)
    );

    i2cms_byte_ram #(
        .DEPTH  (RX_DEPTH),
        .ADDR_W (RX_ADDR_W)
    ) u_rx_ram (
        .clk     (clk),
        .wr_en   (rx_wr_en),
        .wr_addr (rx_wr_addr),
        .wr_data (in_byte),
        .rd_en   (rx_rd_en),
        .rd_addr (rx_rd_addr),
        .rd_data (rx_rd_data)
    );

    // middle stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s2_valid_reg <= s_tvalid;
        end
    end

    // middle stage payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s2_reg <= s1;
        end
    end

    // merge memory read data into the result
    assign s2_bus_byte = s2_reg.sel_tx_data ? tx_rd_data : s2_reg.bus_byte;
    assign s2_rx_byte  = s2_reg.sel_rx_data ? rx_rd_data : '0;

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            out_action_reg <= s2_reg.action;
            out_data_reg   <= {
                (OUT_DATA_W - OUT_USED_W)'(0),
                s2_reg.tx_level,
                s2_reg.rx_level,
                s2_reg.rx_busy,
                s2_reg.tx_busy,
                s2_reg.dropped,
                s2_reg.sel_rx_data,
                s2_rx_byte,
                s2_bus_byte
            };
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_action_reg;

    // read pointers never pass write pointers, write pointers stay in range
    assert property (@(posedge clk) disable iff (!rst_n)
        (tx_rd_ptr_reg <= tx_wr_ptr_reg) && (tx_wr_ptr_reg <= TX_FULL))
        else $error("tx pointers out of order");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rx_rd_ptr_reg <= rx_wr_ptr_reg) && (rx_wr_ptr_reg <= RX_FULL))
        else $error("rx pointers out of order");

    // a stalled middle stage must keep its memory read data
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_move) |-> (!tx_rd_en && !rx_rd_en))
        else $error("memory read while middle stage stalled");

    // a memory read result is always picked up by the next stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (tx_rd_en || rx_rd_en) |=> s2_valid_reg)
        else $error("memory read without a request in the middle stage");

endmodule

/* design/i2cms_byte_ram.sv */
// byte-wide synchronous memory, one write and one read port, registered read
// depends on i2cms_pkg for the byte width
module i2cms_byte_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [i2cms_pkg::BYTE_W-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic [i2cms_pkg::BYTE_W-1:0] rd_data
);
    import i2cms_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* sim/tb_i2c_master_transfer_sequencer_top.sv */
// testbench for i2c_master_transfer_sequencer_top: directed transfers, then random request traffic
// depends on i2cms_pkg and the top level; a built-in predictor checks every result
`timescale 1ns / 100ps

module tb_i2c_master_transfer_sequencer_top;

    import i2cms_pkg::*;

    localparam int TX_SLOTS = 64;
    localparam int RX_SLOTS = 64;

    // codes the package leaves unnamed
    localparam logic [OP_W-1:0]     OP_RESERVED_A = 3'd6;
    localparam logic [OP_W-1:0]     OP_RESERVED_B = 3'd7;
    localparam logic [STATUS_W-1:0] ST_ARB_LOST   = 4'd6;
    localparam logic [STATUS_W-1:0] ST_BUS_ERROR  = 4'd11;
    localparam logic [STATUS_W-1:0] ST_TOP_CODE   = 4'd15;

    localparam int RANDOM_REQUESTS = 1100;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic                block_start;
        logic [BYTE_W-1:0]   load_byte;
        logic [BYTE_W-1:0]   rx_length;
        logic [STATUS_W-1:0] bus_status;
    } xfer_req_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [BYTE_W-1:0]   bus_byte;
        logic [BYTE_W-1:0]   rx_byte;
        logic                rx_valid;
        logic                dropped;
        logic                tx_busy;
        logic                rx_busy;
        logic [LEVEL_W-1:0]  rx_level;
        logic [LEVEL_W-1:0]  tx_level;
    } bus_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [ADDR7_W-1:0]    cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [OP_W-1:0]       s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [ACTION_W-1:0]   m_tuser;

    // transfer state mirror
    logic [BYTE_W-1:0]  tx_mem [TX_SLOTS];
    logic [BYTE_W-1:0]  rx_mem [RX_SLOTS];
    int                 tx_fill;
    int                 tx_next;
    int                 rx_fill;
    int                 rx_next;
    logic [BYTE_W-1:0]  acks_left;
    logic               read_dir;
    logic               tx_act;
    logic               rx_act;
    logic [ADDR7_W-1:0] dev_addr;

    bus_result_t pending_results [$];
    bus_result_t want;

    int  error_count;
    int  results_seen;
    int  requests_sent;
    int  useful_sent;
    int  addr_settings;
    int  drops_seen;
    int  pops_seen;
    int  hold_cycles;
    bit  no_idle;

    i2c_master_transfer_sequencer_top #(
        .TX_DEPTH (TX_SLOTS),
        .RX_DEPTH (RX_SLOTS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #1_000_000;
        $display("tb_i2c_master_transfer_sequencer_top failed");
        $finish;
    end

    // idle length: mostly none or short, sometimes long
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ack or nack for the next received byte
    function automatic logic [ACTION_W-1:0] next_ack_action();
        if (acks_left > 0)
        begin
            acks_left--;
            return ACT_RX_ACK;
        end
        rx_act = 1'b0;
        return ACT_RX_NACK;
    endfunction

    // expected result of one request, advancing the mirrored state
    function automatic bus_result_t predict_transfer_step(input xfer_req_t rq);
        bus_result_t r;
        r = '0;
        case (rq.op)
            OP_LOAD_TX:
            begin
                if (rq.block_start)
                begin
                    tx_fill = 0;
                    tx_next = 0;
                end
                if (tx_fill < TX_SLOTS)
                begin
                    tx_mem[tx_fill] = rq.load_byte;
                    tx_fill++;
                end
                else
                    r.dropped = 1'b1;
            end
            OP_START_WR:
            begin
                read_dir = 1'b0;
                tx_act   = 1'b1;
                tx_next  = 0;
                r.action = ACT_START;
            end
            OP_START_RD:
            begin
                read_dir  = 1'b1;
                acks_left = rq.rx_length;
                rx_fill   = 0;
                rx_next   = 0;
                rx_act    = 1'b1;
                r.action  = ACT_START;
            end
            OP_BUS_EVENT:
            begin
                case (rq.bus_status)
                    ST_START, ST_REP_START:
                    begin
                        r.action   = ACT_SEND_ADDR;
                        r.bus_byte = {dev_addr, read_dir};
                    end
                    ST_SLAW_ACK, ST_DATA_ACK:
                    begin
                        if (tx_next < tx_fill)
                        begin
                            r.action   = ACT_SEND_DATA;
                            r.bus_byte = tx_mem[tx_next];
                            tx_next++;
                        end
                        else
                        begin
                            r.action = ACT_STOP;
                            tx_act   = 1'b0;
                        end
                    end
                    ST_RX_ACK:
                    begin
                        // byte is dropped silently once the receive side is full
                        if (rx_fill < RX_SLOTS)
                        begin
                            rx_mem[rx_fill] = rq.load_byte;
                            rx_fill++;
                        end
                        r.action = next_ack_action();
                    end
                    ST_SLAR_ACK:
                        r.action = next_ack_action();
                    ST_SLAW_NACK, ST_DATA_NACK, ST_SLAR_NACK, ST_RX_NACK:
                    begin
                        r.action = ACT_STOP;
                        tx_act   = 1'b0;
                        rx_act   = 1'b0;
                    end
                    default:
                        ;
                endcase
            end
            OP_STOP:
            begin
                r.action = ACT_STOP;
                tx_act   = 1'b0;
                rx_act   = 1'b0;
            end
            OP_POP_RX:
            begin
                if (rx_next < rx_fill)
                begin
                    r.rx_byte  = rx_mem[rx_next];
                    r.rx_valid = 1'b1;
                    rx_next++;
                end
            end
            default:
                ;
        endcase
        r.tx_busy  = tx_act;
        r.rx_busy  = rx_act;
        r.rx_level = LEVEL_W'(rx_fill - rx_next);
        r.tx_level = LEVEL_W'(tx_fill - tx_next);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want_v);
        error_count++;
        if (error_count <= 40)
            $display("result %0d %s: got %0h, expected %0h", results_seen, what, got, want_v);
    endtask

    task automatic check_field(input string what, input logic [7:0] got,
                               input logic [7:0] want_v);
        if (got !== want_v)
            report_mismatch(what, got, want_v);
    endtask

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, action", 8'(m_tuser), 8'h00);
            else
            begin
                want = pending_results.pop_front();
                check_field("bus_action", 8'(m_tuser), 8'(want.action));
                check_field("bus_byte", m_tdata[7:0], want.bus_byte);
                check_field("rx_byte", m_tdata[15:8], want.rx_byte);
                check_field("rx_byte_valid", 8'(m_tdata[16]), 8'(want.rx_valid));
                check_field("write_dropped", 8'(m_tdata[17]), 8'(want.dropped));
                check_field("tx_busy", 8'(m_tdata[18]), 8'(want.tx_busy));
                check_field("rx_busy", 8'(m_tdata[19]), 8'(want.rx_busy));
                check_field("rx_level", 8'(m_tdata[26:20]), 8'(want.rx_level));
                check_field("tx_level", 8'(m_tdata[33:27]), 8'(want.tx_level));
                if (want.dropped)
                    drops_seen++;
                if (want.rx_valid)
                    pops_seen++;
                results_seen++;
            end
        end
    end

    // result side: random stalls, plus long hold-offs on demand
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                stall_left  = hold_cycles;
                hold_cycles = 0;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // offer one request and wait for it to be taken
    task automatic send_request(input logic [OP_W-1:0] op, input logic blk,
                                input logic [7:0] data, input logic [7:0] len,
                                input logic [STATUS_W-1:0] status);
        int        gap;
        xfer_req_t rq;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(IN_DATA_W - IN_STAT_LO - STATUS_W){1'b0}}, status, len, data, blk};
        do @(posedge clk); while (s_tready !== 1'b1);
        rq.op          = op;
        rq.block_start = blk;
        rq.load_byte   = data;
        rq.rx_length   = len;
        rq.bus_status  = status;
        pending_results.push_back(predict_transfer_step(rq));
        requests_sent++;
        if (op <= OP_POP_RX)
            useful_sent++;
    endtask

    // request whose payload fields do not matter
    task automatic send_op(input logic [OP_W-1:0] op);
        send_request(op, 1'($urandom), 8'($urandom), 8'($urandom), 4'($urandom));
    endtask

    task automatic load_tx(input logic blk, input logic [7:0] data);
        send_request(OP_LOAD_TX, blk, data, 8'($urandom), 4'($urandom));
    endtask

    task automatic start_read(input logic [7:0] len);
        send_request(OP_START_RD, 1'($urandom), 8'($urandom), len, 4'($urandom));
    endtask

    task automatic bus_event(input logic [STATUS_W-1:0] status, input logic [7:0] data);
        send_request(OP_BUS_EVENT, 1'($urandom), data, 8'($urandom), status);
    endtask

    // pause the request side until every result is back
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    task automatic set_dev_addr(input logic [ADDR7_W-1:0] addr);
        wait_all_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= addr;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        dev_addr = addr;
        addr_settings++;
    endtask

    // requests that find nothing to do or are ignored
    task automatic test_idle_requests();
        send_op(OP_POP_RX);
        bus_event(ST_DATA_ACK, 8'h00);
        send_op(OP_RESERVED_A);
        send_op(OP_RESERVED_B);
        bus_event(ST_ARB_LOST, 8'hFF);
        bus_event(ST_BUS_ERROR, 8'h5A);
        bus_event(ST_TOP_CODE, 8'hA5);
    endtask

    // short write, resend after rewind, nack endings
    task automatic test_write_transfer();
        load_tx(1'b1, 8'h00);
        load_tx(1'b0, 8'hFF);
        send_op(OP_START_WR);
        bus_event(ST_START, 8'h00);
        bus_event(ST_SLAW_ACK, 8'h00);
        bus_event(ST_DATA_ACK, 8'h00);
        bus_event(ST_DATA_ACK, 8'h00);
        send_op(OP_START_WR);
        bus_event(ST_REP_START, 8'hFF);
        bus_event(ST_SLAW_NACK, 8'hFF);
        bus_event(ST_DATA_NACK, 8'hFF);
    endtask

    // one-byte read, pop, stop, maximum length with address nack
    task automatic test_read_transfer();
        set_dev_addr(7'd0);
        start_read(8'd1);
        bus_event(ST_START, 8'h00);
        bus_event(ST_SLAR_ACK, 8'h00);
        bus_event(ST_RX_ACK, 8'hFF);
        bus_event(ST_RX_NACK, 8'h00);
        send_op(OP_POP_RX);
        send_op(OP_STOP);
        start_read(8'hFF);
        bus_event(ST_SLAR_NACK, 8'h00);
    endtask

    // result side holds off long while requests keep coming
    task automatic test_output_stall();
        int i;
        wait_all_results();
        no_idle     = 1'b1;
        hold_cycles = 60;
        for (i = 0; i < 24; i++)
            load_tx(i == 0, 8'($urandom));
        no_idle = 1'b0;
        wait_all_results();
    endtask

    // random well-formed transfers mixed with noise
    task automatic test_random_traffic();
        int kind;
        int n;
        int i;
        int next_cfg;
        next_cfg = useful_sent + 150;
        while (useful_sent < RANDOM_REQUESTS + 30)
        begin
            if (useful_sent >= next_cfg)
            begin
                set_dev_addr(7'($urandom_range(0, 127)));
                next_cfg = useful_sent + 150;
            end
            no_idle = ($urandom_range(0, 9) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 35)
            begin
                // write: optional fresh block, address, data until stop
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70)
                                                 : $urandom_range(1, 8);
                if ($urandom_range(0, 3) != 0)
                    for (i = 0; i < n; i++)
                        load_tx(i == 0, 8'($urandom));
                send_op(OP_START_WR);
                bus_event($urandom_range(0, 1) ? ST_START : ST_REP_START, 8'($urandom));
                if ($urandom_range(0, 9) == 0)
                    bus_event(ST_SLAW_NACK, 8'($urandom));
                else
                begin
                    bus_event(ST_SLAW_ACK, 8'($urandom));
                    for (i = 0; i < n; i++)
                    begin
                        if ($urandom_range(0, 29) == 0)
                        begin
                            bus_event(ST_DATA_NACK, 8'($urandom));
                            break;
                        end
                        bus_event(ST_DATA_ACK, 8'($urandom));
                    end
                end
                if ($urandom_range(0, 1) == 0)
                    send_op(OP_STOP);
            end
            else if (kind < 70)
            begin
                // read: address, acked bytes, final nack, then pops
                i = $urandom_range(0, 19);
                if (i == 0)
                    n = 255;
                else if (i < 3)
                    n = $urandom_range(60, 70);
                else
                    n = $urandom_range(0, 8);
                start_read(8'(n));
                bus_event($urandom_range(0, 1) ? ST_START : ST_REP_START, 8'($urandom));
                if ($urandom_range(0, 9) == 0)
                    bus_event(ST_SLAR_NACK, 8'($urandom));
                else
                begin
                    bus_event(ST_SLAR_ACK, 8'($urandom));
                    if (n > 70)
                        n = 70;
                    for (i = 0; i < n; i++)
                        bus_event(ST_RX_ACK, 8'($urandom));
                    bus_event(ST_RX_NACK, 8'($urandom));
                end
                n = $urandom_range(0, n + 2);
                for (i = 0; i < n; i++)
                    send_op(OP_POP_RX);
            end
            else if (kind < 90)
            begin
                // noise: any opcode, any field values
                n = $urandom_range(1, 4);
                for (i = 0; i < n; i++)
                    send_request(3'($urandom), 1'($urandom), 8'($urandom),
                                 8'($urandom), 4'($urandom));
            end
            else
            begin
                n = $urandom_range(1, 5);
                for (i = 0; i < n; i++)
                    send_op(OP_POP_RX);
            end
            if ($urandom_range(0, 29) == 0)
                wait_all_results();
        end
        no_idle = 1'b0;
    endtask

    // main sequence
    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_LOAD_TX;
        no_idle     = 1'b0;
        hold_cycles = 0;
        tx_fill     = 0;
        tx_next     = 0;
        rx_fill     = 0;
        rx_next     = 0;
        acks_left   = '0;
        read_dir    = 1'b0;
        tx_act      = 1'b0;
        rx_act      = 1'b0;
        dev_addr    = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_dev_addr(7'd127);
        test_idle_requests();
        test_write_transfer();
        test_read_transfer();
        test_output_stall();
        test_random_traffic();

        // let any stray result show up
        wait_all_results();
        repeat (10) @(posedge clk);

        $display("%0d requests, %0d results checked, %0d slave address settings",
                 requests_sent, results_seen, addr_settings);
        $display("%0d dropped loads and %0d received bytes popped were predicted",
                 drops_seen, pops_seen);
        if (error_count == 0)
            $display("tb_i2c_master_transfer_sequencer_top passed");
        else
            $display("tb_i2c_master_transfer_sequencer_top failed");
        $finish;
    end

endmodule
